### design/skre_pkg.sv
// Shared constants and types for the spike key row expander.
package skre_pkg;

    localparam int TABLE_DEPTH = 16;
    localparam int IDX_W       = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
    localparam int CFG_W       = 5;
    localparam int SLOT_W      = 4;
    localparam int DATA_W      = 32;
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam logic KIND_LOAD  = 1'b0;
    localparam logic KIND_SPIKE = 1'b1;

    // One classified request. For a spike the key field carries the spike key.
    typedef struct packed {
        logic              is_spike;
        logic              slot_ok;
        logic [SLOT_W-1:0] slot;
        logic [DATA_W-1:0] key;
        logic [DATA_W-1:0] mask;
        logic [DATA_W-1:0] offset;
        logic [DATA_W-1:0] nmask;
    } t_cmd;

endpackage

### design/skre_front.sv
// Front end: accepts requests, classifies them and queues them for the back end.
module skre_front
    import skre_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  logic              i_kind,
    input  logic [SLOT_W-1:0] i_entry_index,
    input  logic [DATA_W-1:0] i_entry_key,
    input  logic [DATA_W-1:0] i_entry_mask,
    input  logic [DATA_W-1:0] i_entry_offset,
    input  logic [DATA_W-1:0] i_entry_neuron_mask,
    input  logic [DATA_W-1:0] i_spike_key,
    output logic              o_head_valid,
    output t_cmd              o_head,
    input  logic              i_pop
);

    t_cmd              r_q [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wp;
    logic [QPTR_W-1:0] r_rp;
    logic [QCNT_W-1:0] r_cnt;
    t_cmd              cmd;
    logic              push;
    logic              pop;
    logic [31:0]       slot_ext;

    always_comb begin
        slot_ext     = 32'(i_entry_index);
        cmd.is_spike = (i_kind == KIND_SPIKE);
        cmd.slot_ok  = (slot_ext < 32'(TABLE_DEPTH));
        cmd.slot     = i_entry_index;
        cmd.key      = (i_kind == KIND_SPIKE) ? i_spike_key : i_entry_key;
        cmd.mask     = i_entry_mask;
        cmd.offset   = i_entry_offset;
        cmd.nmask    = i_entry_neuron_mask;
    end

    assign o_in_ready   = (r_cnt < QCNT_W'(QUEUE_DEPTH));
    assign o_head_valid = (r_cnt != '0);
    assign o_head       = r_q[r_rp];
    assign push         = i_in_valid && o_in_ready;
    assign pop          = i_pop && o_head_valid;

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wp] <= cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (push) begin
                r_wp <= (r_wp == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_wp + QPTR_W'(1);
            end
            if (pop) begin
                r_rp <= (r_rp == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_rp + QPTR_W'(1);
            end
            if (push && !pop) begin
                r_cnt <= r_cnt + QCNT_W'(1);
            end else if (pop && !push) begin
                r_cnt <= r_cnt - QCNT_W'(1);
            end
        end
    end

endmodule

### design/skre_back.sv
// Back end: routing table, result reg, stallable 1-entry/cycle key scan.
module skre_back
    import skre_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic [CFG_W-1:0]  i_entry_count,
    input  logic              i_head_valid,
    input  t_cmd              i_head,
    output logic              o_pop,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output logic [DATA_W-1:0] o_row_index,
    output logic              o_no_match,
    output logic              o_last
);

    typedef enum logic {S_IDLE, S_SCAN} t_state;

    t_state            r_state;
    logic [DATA_W-1:0] r_key    [TABLE_DEPTH];
    logic [DATA_W-1:0] r_mask   [TABLE_DEPTH];
    logic [DATA_W-1:0] r_offset [TABLE_DEPTH];
    logic [DATA_W-1:0] r_nmask  [TABLE_DEPTH];
    logic [DATA_W-1:0] r_spike;
    logic [CNT_W-1:0]  r_limit;
    logic [CNT_W-1:0]  r_n;
    logic              r_has_pend;
    logic [DATA_W-1:0] r_pend;
    logic              r_out_valid;
    logic [DATA_W-1:0] r_out_row;
    logic              r_out_no_match;
    logic              r_out_last;

    logic [IDX_W-1:0]  rd_idx;
    logic [IDX_W-1:0]  wr_idx;
    logic [31:0]       slot_ext;
    logic [31:0]       cnt_ext;
    logic [CNT_W-1:0]  limit;
    logic              hit;
    logic [DATA_W-1:0] row;
    logic              out_free;
    logic              emit;

    always_comb begin
        slot_ext = 32'(i_head.slot);
        wr_idx   = slot_ext[IDX_W-1:0];
        cnt_ext  = 32'(i_entry_count);
        limit    = CNT_W'((cnt_ext > 32'(TABLE_DEPTH)) ? 32'(TABLE_DEPTH) : cnt_ext);
        rd_idx   = r_n[IDX_W-1:0];
        hit      = ((r_spike & r_mask[rd_idx]) == r_key[rd_idx]);
        row      = r_offset[rd_idx] + (r_spike & r_nmask[rd_idx]);
        out_free = !r_out_valid || i_out_ready;
        emit     = (r_state == S_SCAN) && out_free &&
                   ((r_n == r_limit) || (hit && r_has_pend));
    end

    assign o_pop       = (r_state == S_IDLE) && i_head_valid;
    assign o_out_valid = r_out_valid;
    assign o_row_index = r_out_row;
    assign o_no_match  = r_out_no_match;
    assign o_last      = r_out_last;

    always_ff @(posedge i_clk) begin
        if (o_pop && !i_head.is_spike && i_head.slot_ok) begin
            r_key[wr_idx]    <= i_head.key;
            r_mask[wr_idx]   <= i_head.mask;
            r_offset[wr_idx] <= i_head.offset;
            r_nmask[wr_idx]  <= i_head.nmask;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_has_pend  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (emit) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (i_head_valid && i_head.is_spike) begin
                        r_spike    <= i_head.key;
                        r_limit    <= limit;
                        r_n        <= '0;
                        r_has_pend <= 1'b0;
                        r_state    <= S_SCAN;
                    end
                end
                S_SCAN: begin
                    if (r_n == r_limit) begin
                        if (out_free) begin
                            r_out_row      <= r_has_pend ? r_pend : '0;
                            r_out_no_match <= !r_has_pend;
                            r_out_last     <= 1'b1;
                            r_state        <= S_IDLE;
                        end
                    end else if (hit) begin
                        if (!r_has_pend) begin
                            r_pend     <= row;
                            r_has_pend <= 1'b1;
                            r_n        <= r_n + CNT_W'(1);
                        end else if (out_free) begin
                            // previous match is known not to be the last one
                            r_out_row      <= r_pend;
                            r_out_no_match <= 1'b0;
                            r_out_last     <= 1'b0;
                            r_pend         <= row;
                            r_n            <= r_n + CNT_W'(1);
                        end
                    end else begin
                        r_n <= r_n + CNT_W'(1);
                    end
                end
            endcase
        end
    end

endmodule

### design/spike_key_row_expander.sv
// Top level of the spike key row expander: entry count register, front end and back end.
// The back end scans entry_count table entries (capped at 16), one entry per cycle unless a
// match waits for the result register. The first result is emitted when a second match is
// found, or at the end of the scan with fewer than two matches. The front end queue accepts
// requests while a spike is scanned; the back end takes the next request only when idle.
// Reset: synchronous, active low; clears queue, scan, result and entry_count, not the table.
module spike_key_row_expander
    import skre_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  logic [CFG_W-1:0]  i_cfg_wdata,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  logic              i_kind,
    input  logic [SLOT_W-1:0] i_entry_index,
    input  logic [DATA_W-1:0] i_entry_key,
    input  logic [DATA_W-1:0] i_entry_mask,
    input  logic [DATA_W-1:0] i_entry_offset,
    input  logic [DATA_W-1:0] i_entry_neuron_mask,
    input  logic [DATA_W-1:0] i_spike_key,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output logic [DATA_W-1:0] o_row_index,
    output logic              o_no_match,
    output logic              o_last
);

    logic [CFG_W-1:0] r_entry_count;
    logic             head_valid;
    t_cmd             head;
    logic             pop;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_entry_count <= '0;
        end else if (i_cfg_we) begin
            r_entry_count <= i_cfg_wdata;
        end
    end

    skre_front u_front (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_in_valid          (i_in_valid),
        .o_in_ready          (o_in_ready),
        .i_kind              (i_kind),
        .i_entry_index       (i_entry_index),
        .i_entry_key         (i_entry_key),
        .i_entry_mask        (i_entry_mask),
        .i_entry_offset      (i_entry_offset),
        .i_entry_neuron_mask (i_entry_neuron_mask),
        .i_spike_key         (i_spike_key),
        .o_head_valid        (head_valid),
        .o_head              (head),
        .i_pop               (pop)
    );

    skre_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_entry_count (r_entry_count),
        .i_head_valid  (head_valid),
        .i_head        (head),
        .o_pop         (pop),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_row_index   (o_row_index),
        .o_no_match    (o_no_match),
        .o_last        (o_last)
    );

endmodule
